### hw/rtl/plc_pkg.sv
// Shared types and constants for the piecewise linear colormap.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package plc_pkg;

    localparam int MAX_POINTS  = 6;
    localparam int VALUE_BITS  = 24;
    localparam int COLOR_BITS  = 24;
    localparam int CH_BITS     = 8;
    localparam int CNT_BITS    = 3;
    localparam int IDX_BITS    = 3;
    localparam int SEG_BITS    = 3;
    localparam int DIV_BITS    = VALUE_BITS + CH_BITS;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = 2;
    // Back pipeline: select, multiply, then one stage per quotient bit
    localparam int BACK_STAGES = CH_BITS + 2;

    // Register indexes of the configuration port
    localparam logic [IDX_BITS-1:0] REG_FULL_SCALE  = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_POINT_COUNT = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_COLOR_BASE  = 3'd2;

    typedef enum logic [1:0] {
        SU_LOAD,
        SU_DIV,
        SU_MUL,
        SU_DONE
    } t_setup_state;

    // Settled configuration as seen by the datapath
    typedef struct packed {
        logic                                    bad;
        logic [SEG_BITS-1:0]                     span;
        logic [VALUE_BITS-1:0]                   full_scale;
        logic [MAX_POINTS-1:0][VALUE_BITS-1:0]   mult;
        logic [MAX_POINTS-1:0][COLOR_BITS-1:0]   color;
    } t_cfg;

    // Classified beat handed from front to back
    typedef struct packed {
        logic                  last;
        logic [SEG_BITS-1:0]   seg;
        logic [VALUE_BITS-1:0] rem;
    } t_item;

    function automatic logic [COLOR_BITS-1:0] pick_color(
        input t_cfg cfg, input logic [SEG_BITS-1:0] idx);
        logic [COLOR_BITS-1:0] c;
        begin
            c = '0;
            unique case (idx)
                3'd0:    c = cfg.color[0];
                3'd1:    c = cfg.color[1];
                3'd2:    c = cfg.color[2];
                3'd3:    c = cfg.color[3];
                3'd4:    c = cfg.color[4];
                3'd5:    c = cfg.color[5];
                default: c = '0;
            endcase
            return c;
        end
    endfunction

endpackage
`default_nettype wire

### hw/rtl/plc_setup.sv
// Configuration registers plus derived step and segment boundaries.
// Depends on plc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module plc_setup (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [plc_pkg::IDX_BITS-1:0]      i_cfg_index,
    input  wire [plc_pkg::COLOR_BITS-1:0]    i_cfg_data,
    output plc_pkg::t_cfg                    o_cfg,
    output logic                             o_done
);

    logic [plc_pkg::VALUE_BITS-1:0]                         r_fs;
    logic [plc_pkg::CNT_BITS-1:0]                           r_pc;
    logic [plc_pkg::MAX_POINTS-1:0][plc_pkg::COLOR_BITS-1:0] r_cp;
    logic [plc_pkg::MAX_POINTS-1:0][plc_pkg::VALUE_BITS-1:0] r_mult;
    logic [plc_pkg::VALUE_BITS-1:0]                         r_quo;
    logic [plc_pkg::SEG_BITS-1:0]                           r_rem;
    logic [plc_pkg::VALUE_BITS-1:0]                         r_acc;
    logic [4:0]                                             r_cnt;
    plc_pkg::t_setup_state                                  r_state, n_state;

    logic [plc_pkg::CNT_BITS-1:0]   pts;
    logic                           bad;
    logic [plc_pkg::SEG_BITS-1:0]   span;
    logic [plc_pkg::SEG_BITS:0]     div_t;
    logic                           div_ge;
    logic [plc_pkg::VALUE_BITS-1:0] acc_nx;
    logic                           do_load, do_div, do_mul;

    // Point count saturation and divide-by-zero detection
    always_comb begin
        pts  = (r_pc > 3'(plc_pkg::MAX_POINTS)) ? 3'(plc_pkg::MAX_POINTS) : r_pc;
        bad  = (r_pc < 3'd2) || (r_fs < 24'(pts - 3'd1));
        span = bad ? 3'd1 : (pts - 3'd1);
    end

    // Register writes; point 1 resets to white, the rest to black
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs <= 24'd255;
            r_pc <= 3'd2;
            r_cp <= {{(plc_pkg::MAX_POINTS-2){24'h000000}}, 24'hFFFFFF, 24'h000000};
        end else if (i_cfg_we) begin
            if (i_cfg_index == plc_pkg::REG_FULL_SCALE) begin
                r_fs <= i_cfg_data;
            end else if (i_cfg_index == plc_pkg::REG_POINT_COUNT) begin
                r_pc <= i_cfg_data[plc_pkg::CNT_BITS-1:0];
            end else begin
                r_cp[i_cfg_index - plc_pkg::REG_COLOR_BASE] <= i_cfg_data;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        if (i_cfg_we) begin
            n_state = plc_pkg::SU_LOAD;
        end else begin
            unique case (r_state)
                plc_pkg::SU_LOAD: n_state = plc_pkg::SU_DIV;
                plc_pkg::SU_DIV:  if (r_cnt == 5'(plc_pkg::VALUE_BITS - 1)) begin
                    n_state = plc_pkg::SU_MUL;
                end
                plc_pkg::SU_MUL:  if (r_cnt == 5'(plc_pkg::MAX_POINTS - 1)) begin
                    n_state = plc_pkg::SU_DONE;
                end
                plc_pkg::SU_DONE: n_state = plc_pkg::SU_DONE;
                default:          n_state = plc_pkg::SU_LOAD;
            endcase
        end
    end

    // State outputs
    always_comb begin
        do_load = 1'b0;
        do_div  = 1'b0;
        do_mul  = 1'b0;
        o_done  = 1'b0;
        unique case (r_state)
            plc_pkg::SU_LOAD: do_load = 1'b1;
            plc_pkg::SU_DIV:  do_div  = 1'b1;
            plc_pkg::SU_MUL:  do_mul  = 1'b1;
            plc_pkg::SU_DONE: o_done  = 1'b1;
            default:          do_load = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plc_pkg::SU_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // One quotient bit per cycle: step = full_scale / span
    always_comb begin
        div_t  = {r_rem, r_quo[plc_pkg::VALUE_BITS-1]};
        div_ge = (div_t >= {1'b0, span});
        acc_nx = r_acc + r_quo;
    end

    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_quo    <= r_fs;
            r_rem    <= '0;
            r_acc    <= '0;
            r_cnt    <= '0;
            r_mult   <= '0;
        end else if (do_div) begin
            r_rem <= div_ge ? 3'(div_t - {1'b0, span}) : div_t[plc_pkg::SEG_BITS-1:0];
            r_quo <= {r_quo[plc_pkg::VALUE_BITS-2:0], div_ge};
            r_cnt <= (r_cnt == 5'(plc_pkg::VALUE_BITS - 1)) ? 5'd1 : r_cnt + 5'd1;
        end else if (do_mul) begin
            // Boundaries k*step, one per cycle
            r_acc <= acc_nx;
            r_mult[r_cnt[2:0]] <= acc_nx;
            r_cnt <= r_cnt + 5'd1;
        end
    end

    always_comb begin
        o_cfg.bad        = bad;
        o_cfg.span       = span;
        o_cfg.full_scale = r_fs;
        o_cfg.mult       = r_mult;
        o_cfg.color      = r_cp;
    end

endmodule
`default_nettype wire

### hw/rtl/plc_front.sv
// Front end: takes input beats and finds segment and remainder.
// Depends on plc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module plc_front (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire [plc_pkg::VALUE_BITS-1:0]    i_value,
    input  plc_pkg::t_cfg                    i_cfg,
    input  wire                              i_enable,
    output logic                             o_push,
    output plc_pkg::t_item                   o_item,
    input  wire                              i_full
);

    logic                           r_fv;
    logic [plc_pkg::VALUE_BITS-1:0] r_val;
    logic [plc_pkg::SEG_BITS-1:0]   seg;
    logic [plc_pkg::VALUE_BITS-1:0] base;

    assign o_push  = r_fv && !i_full;
    assign o_ready = i_enable && (!r_fv || !i_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_fv <= 1'b1;
        end else if (o_push) begin
            r_fv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_val <= i_value;
        end
    end

    // Segment = count of boundaries at or below the value
    always_comb begin
        seg = '0;
        for (int k = 1; k < plc_pkg::MAX_POINTS; k++) begin
            if ((3'(k) <= i_cfg.span) && (r_val >= i_cfg.mult[k])) begin
                seg = seg + 3'd1;
            end
        end
        base = '0;
        unique case (seg)
            3'd1:    base = i_cfg.mult[1];
            3'd2:    base = i_cfg.mult[2];
            3'd3:    base = i_cfg.mult[3];
            3'd4:    base = i_cfg.mult[4];
            3'd5:    base = i_cfg.mult[5];
            default: base = '0;
        endcase
        o_item.seg  = seg;
        o_item.last = (seg == i_cfg.span);
        o_item.rem  = r_val - base;
    end

endmodule
`default_nettype wire

### hw/rtl/plc_fifo.sv
// Short queue of classified beats between front and back.
// Depends on plc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module plc_fifo (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  plc_pkg::t_item       i_data,
    output logic                 o_full,
    input  wire                  i_pop,
    output plc_pkg::t_item       o_data,
    output logic                 o_empty
);

    plc_pkg::t_item               r_mem [plc_pkg::Q_DEPTH];
    logic [plc_pkg::Q_AW-1:0]     r_wp, r_rp;
    logic [plc_pkg::Q_AW:0]       r_count;

    assign o_full  = (r_count == (plc_pkg::Q_AW + 1)'(plc_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (plc_pkg::Q_AW + 1)'(plc_pkg::Q_DEPTH))
        else $error("queue count past depth");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not grow on push");

endmodule
`default_nettype wire

### hw/rtl/plc_back.sv
// Back end: color select, scaling multiply, 8-stage divide, output register.
// Depends on plc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module plc_back (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  plc_pkg::t_cfg                    i_cfg,
    input  plc_pkg::t_item                   i_item,
    input  wire                              i_empty,
    output logic                             o_pop,
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic [plc_pkg::CH_BITS-1:0]      o_red,
    output logic [plc_pkg::CH_BITS-1:0]      o_green,
    output logic [plc_pkg::CH_BITS-1:0]      o_blue,
    output logic                             o_bad_setting
);

    logic                                         en;
    logic [plc_pkg::BACK_STAGES-1:0]              r_pv;
    logic                                         r_bad  [plc_pkg::BACK_STAGES];
    logic [2:0]                                   r_fall [plc_pkg::BACK_STAGES];
    logic [2:0][plc_pkg::CH_BITS-1:0]             r_s    [plc_pkg::BACK_STAGES];
    logic [2:0][plc_pkg::CH_BITS-1:0]             r_d;
    logic [plc_pkg::VALUE_BITS-1:0]               r_x;
    logic [2:0][plc_pkg::DIV_BITS-1:0]            r_r    [plc_pkg::BACK_STAGES];
    logic [2:0][plc_pkg::CH_BITS-1:0]             r_q    [plc_pkg::BACK_STAGES];
    logic                                         r_ov;
    logic [2:0][plc_pkg::CH_BITS-1:0]             r_out;
    logic                                         r_obad;

    logic [plc_pkg::COLOR_BITS-1:0]               s_col, e_col;
    logic [2:0][plc_pkg::CH_BITS-1:0]             s_ch, e_ch, d_ch;
    logic [2:0]                                   fall;
    logic [plc_pkg::VALUE_BITS+plc_pkg::SEG_BITS-1:0] x_full;
    logic [plc_pkg::DIV_BITS-1:0]                 dv [plc_pkg::CH_BITS];

    assign en    = !r_ov || i_ready;
    assign o_pop = en && !i_empty;

    // Stage 0: pick end colors, per-channel magnitude and direction
    always_comb begin
        s_col  = i_item.last ? plc_pkg::pick_color(i_cfg, i_cfg.span)
                             : plc_pkg::pick_color(i_cfg, i_item.seg);
        e_col  = plc_pkg::pick_color(i_cfg, i_item.seg + 3'd1);
        x_full = i_item.rem * i_cfg.span;
        for (int c = 0; c < 3; c++) begin
            s_ch[c] = s_col[plc_pkg::COLOR_BITS-1-8*c -: 8];
            e_ch[c] = e_col[plc_pkg::COLOR_BITS-1-8*c -: 8];
            fall[c] = e_ch[c] < s_ch[c];
            d_ch[c] = i_item.last ? 8'd0
                    : (fall[c] ? s_ch[c] - e_ch[c] : e_ch[c] - s_ch[c]);
        end
    end

    // Divisor shifted for each quotient bit, MSB first
    always_comb begin
        for (int g = 0; g < plc_pkg::CH_BITS; g++) begin
            dv[g] = {{plc_pkg::CH_BITS{1'b0}}, i_cfg.full_scale}
                    << (plc_pkg::CH_BITS - 1 - g);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_pv <= {r_pv[plc_pkg::BACK_STAGES-2:0], o_pop};
            r_ov <= r_pv[plc_pkg::BACK_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bad[0]  <= i_cfg.bad;
            r_fall[0] <= fall;
            r_s[0]    <= s_ch;
            r_d       <= d_ch;
            r_x       <= x_full[plc_pkg::VALUE_BITS-1:0];
            // Stage 1: numerator = rem * span * magnitude
            r_bad[1]  <= r_bad[0];
            r_fall[1] <= r_fall[0];
            r_s[1]    <= r_s[0];
            r_q[1]    <= '0;
            for (int c = 0; c < 3; c++) begin
                r_r[1][c] <= r_x * r_d[c];
            end
            // Stages 2..9: one quotient bit per stage against full_scale
            for (int g = 0; g < plc_pkg::CH_BITS; g++) begin
                r_bad[g+2]  <= r_bad[g+1];
                r_fall[g+2] <= r_fall[g+1];
                r_s[g+2]    <= r_s[g+1];
                for (int c = 0; c < 3; c++) begin
                    if (r_r[g+1][c] >= dv[g]) begin
                        r_r[g+2][c] <= r_r[g+1][c] - dv[g];
                        r_q[g+2][c] <= {r_q[g+1][c][plc_pkg::CH_BITS-2:0], 1'b1};
                    end else begin
                        r_r[g+2][c] <= r_r[g+1][c];
                        r_q[g+2][c] <= {r_q[g+1][c][plc_pkg::CH_BITS-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // Output register: falling channels round toward minus infinity
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_obad <= r_bad[plc_pkg::BACK_STAGES-1];
            for (int c = 0; c < 3; c++) begin
                if (r_bad[plc_pkg::BACK_STAGES-1]) begin
                    r_out[c] <= '0;
                end else if (r_fall[plc_pkg::BACK_STAGES-1][c]) begin
                    r_out[c] <= r_s[plc_pkg::BACK_STAGES-1][c]
                                - r_q[plc_pkg::BACK_STAGES-1][c]
                                - 8'(r_r[plc_pkg::BACK_STAGES-1][c] != '0);
                end else begin
                    r_out[c] <= r_s[plc_pkg::BACK_STAGES-1][c]
                                + r_q[plc_pkg::BACK_STAGES-1][c];
                end
            end
        end
    end

    assign o_valid       = r_ov;
    assign o_red         = r_out[0];
    assign o_green       = r_out[1];
    assign o_blue        = r_out[2];
    assign o_bad_setting = r_obad;

    a_bad_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_setting) |-> (o_red == '0 && o_green == '0 && o_blue == '0))
        else $error("bad setting without black output");
    a_pop_feeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_pv[0])
        else $error("popped beat not in pipeline");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_pv))
        else $error("pipeline moved while stalled");

endmodule
`default_nettype wire

### hw/rtl/piecewise_linear_colormap.sv
// Beats pass the front register, queue, back pipeline and output register.
// Throughput: one beat per cycle; the back pipeline holds as a whole when
// the output stalls, the 4-entry queue absorbs the front meanwhile.
// Reset and every configuration write start a setup (serial step
// divide, then boundary accumulation); no input beat is taken during it.
// Top level of the piecewise linear colormap; depends on plc_pkg, plc_setup,
// plc_front, plc_fifo and plc_back.
`timescale 1ns / 1ps
`default_nettype none
module piecewise_linear_colormap (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [plc_pkg::IDX_BITS-1:0]      i_cfg_index,
    input  wire [plc_pkg::COLOR_BITS-1:0]    i_cfg_data,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire [plc_pkg::VALUE_BITS-1:0]    i_value,
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic [plc_pkg::CH_BITS-1:0]      o_red,
    output logic [plc_pkg::CH_BITS-1:0]      o_green,
    output logic [plc_pkg::CH_BITS-1:0]      o_blue,
    output logic                             o_bad_setting
);

    plc_pkg::t_cfg  cfg;
    plc_pkg::t_item push_item, pop_item;
    logic           done, push, pop, full, empty;

    plc_setup u_setup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_done      (done)
    );

    plc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_value  (i_value),
        .i_cfg    (cfg),
        .i_enable (done && !i_cfg_we),
        .o_push   (push),
        .o_item   (push_item),
        .i_full   (full)
    );

    plc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (pop_item),
        .o_empty (empty)
    );

    plc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_item        (pop_item),
        .i_empty       (empty),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_bad_setting (o_bad_setting)
    );

endmodule
`default_nettype wire

### verif/tb.sv
// Self-checking testbench for piecewise_linear_colormap: random and directed samples
// against a built-in integer model of the RGB interpolation. Also needs plc_pkg.
`timescale 1ns / 1ps
module tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       bad;
    } t_color;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [plc_pkg::IDX_BITS-1:0]   i_cfg_index = '0;
    logic [plc_pkg::COLOR_BITS-1:0] i_cfg_data = '0;
    logic                           i_valid = 1'b0;
    logic                           o_ready;
    logic [plc_pkg::VALUE_BITS-1:0] i_value = '0;
    logic                           o_valid;
    logic                           i_ready = 1'b0;
    logic [7:0]                     o_red, o_green, o_blue;
    logic                           o_bad_setting;

    piecewise_linear_colormap uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_value(i_value),
        .o_valid(o_valid), .i_ready(i_ready), .o_red(o_red),
        .o_green(o_green), .o_blue(o_blue), .o_bad_setting(o_bad_setting)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow copy of the configuration registers
    logic [23:0] scale_reg;
    logic [2:0]  count_reg;
    logic [23:0] palette [0:5];

    t_color expected_colors[$];
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     hold_off = 1'b0;
    int     mismatches = 0;
    int     colors_checked = 0;
    int     idle_cycles = 0;
    int     samples_sent = 0;

    function automatic logic [7:0] chan(logic [23:0] packed_c, int ch);
        return packed_c[16 - 8*ch +: 8];
    endfunction

    // Integer interpolation of one sample
    function automatic t_color map_sample(logic [23:0] v);
        t_color      c;
        int unsigned pts;
        longint unsigned span, stp, seg, rem, mag, num, q, sc;
        logic [7:0]  s, e, r;
        pts = count_reg;
        if (pts > plc_pkg::MAX_POINTS) pts = plc_pkg::MAX_POINTS;
        c = '0;
        if (pts < 2 || scale_reg < pts - 1) begin
            c.bad = 1'b1;
            return c;
        end
        sc   = scale_reg;
        span = pts - 1;
        stp  = sc / span;
        seg  = v / stp;
        rem  = v % stp;
        for (int ch = 0; ch < 3; ch++) begin
            if (seg < span) begin
                s = chan(palette[seg], ch);
                e = chan(palette[seg+1], ch);
                if (e >= s) begin
                    mag = e - s;
                    q = (rem * mag * span) / sc;
                    r = s + q[7:0];
                end else begin
                    mag = s - e;
                    num = rem * mag * span;
                    q = num / sc + ((num % sc) != 0);
                    r = s - q[7:0];
                end
            end else begin
                r = chan(palette[pts-1], ch);
            end
            case (ch)
                0: c.red = r;
                1: c.green = r;
                default: c.blue = r;
            endcase
        end
        return c;
    endfunction

    // Register write, only while idle
    task automatic write_reg(logic [2:0] idx, logic [23:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == plc_pkg::REG_FULL_SCALE) scale_reg = data;
        else if (idx == plc_pkg::REG_POINT_COUNT) count_reg = data[2:0];
        else palette[idx - plc_pkg::REG_COLOR_BASE] = data;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_colors.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Send one sample beat; valid stays up until accepted
    task automatic send_sample(logic [23:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (!o_ready);
        expected_colors.push_back(map_sample(v));
        samples_sent++;
    endtask

    // Random value biased to the ramp and to the edges
    function automatic logic [23:0] rand_value();
        case ($urandom_range(9))
            0: return 24'($urandom);
            1: return 24'hFFFFFF;
            2: return 24'd0;
            default: return 24'($urandom_range(scale_reg + 2));
        endcase
    endfunction

    task automatic random_palette();
        write_reg(plc_pkg::REG_FULL_SCALE,
                  ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(2000)));
        write_reg(plc_pkg::REG_POINT_COUNT, 24'($urandom_range(7)));
        for (int i = 0; i < 6; i++) write_reg(plc_pkg::REG_COLOR_BASE + 3'(i), 24'($urandom));
    endtask

    // Result checker
    always @(posedge i_clk) begin
        i_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && o_valid && i_ready) begin
            t_color got, exp_c;
            got = '{o_red, o_green, o_blue, o_bad_setting};
            if (expected_colors.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected color beat %h", got);
            end else begin
                exp_c = expected_colors.pop_front();
                colors_checked++;
                if (got !== exp_c) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("color mismatch exp r%h g%h b%h bad%b got r%h g%h b%h bad%b",
                                 exp_c.red, exp_c.green, exp_c.blue, exp_c.bad,
                                 got.red, got.green, got.blue, got.bad);
                end
            end
        end
    end

    // Watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic test_reset_defaults();
        send_sample(0);
        send_sample(128);
        send_sample(255);
        send_sample(24'hFFFFFF);
        wait_idle();
    endtask

    task automatic test_directed();
        write_reg(plc_pkg::REG_FULL_SCALE, 24'hFFFFFF);
        write_reg(plc_pkg::REG_POINT_COUNT, 24'd6);
        write_reg(plc_pkg::REG_COLOR_BASE + 3'd0, 24'hFF00FF);
        write_reg(plc_pkg::REG_COLOR_BASE + 3'd1, 24'h00FF00);
        write_reg(plc_pkg::REG_COLOR_BASE + 3'd2, 24'hFFFFFF);
        write_reg(plc_pkg::REG_COLOR_BASE + 3'd3, 24'h000000);
        write_reg(plc_pkg::REG_COLOR_BASE + 3'd4, 24'h80FF01);
        write_reg(plc_pkg::REG_COLOR_BASE + 3'd5, 24'h123456);
        send_sample(0);
        send_sample(24'h7FFFFF);
        send_sample(24'hFFFFFE);
        send_sample(24'hFFFFFF);
        send_sample(24'h333332);
        wait_idle();
        // too many points saturate to six
        write_reg(plc_pkg::REG_POINT_COUNT, 24'd7);
        send_sample(24'h555555);
        send_sample(24'hFFFFFF);
        wait_idle();
        // too few points
        write_reg(plc_pkg::REG_POINT_COUNT, 24'd1);
        send_sample(5);
        wait_idle();
        write_reg(plc_pkg::REG_POINT_COUNT, 24'd0);
        send_sample(24'hFFFFFF);
        wait_idle();
        // scale too small for the point count, then minimal scale
        write_reg(plc_pkg::REG_POINT_COUNT, 24'd6);
        write_reg(plc_pkg::REG_FULL_SCALE, 24'd4);
        send_sample(3);
        wait_idle();
        write_reg(plc_pkg::REG_FULL_SCALE, 24'd5);
        send_sample(0);
        send_sample(1);
        send_sample(6);
        wait_idle();
        write_reg(plc_pkg::REG_POINT_COUNT, 24'd2);
        write_reg(plc_pkg::REG_FULL_SCALE, 24'd1);
        send_sample(0);
        send_sample(1);
        wait_idle();
    endtask

    task automatic test_random(int phase_items, int idle, int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int n = 0; n < phase_items; n++) begin
            if (n % 60 == 0) begin
                wait_idle();
                random_palette();
            end
            send_sample(rand_value());
        end
        wait_idle();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int n = 0; n < 40; n++) send_sample(rand_value());
        join
        wait_idle();
    endtask

    initial begin
        scale_reg = 255;
        count_reg = 2;
        foreach (palette[i]) palette[i] = 0;
        palette[1] = 24'hFFFFFF;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_directed();
        test_random(360, 0, 0);
        test_random(360, 68, 0);
        test_random(360, 0, 68);
        test_random(360, 31, 31);
        test_backpressure();
        $display("covered %0d samples, %0d colors checked over edge and random palettes",
                 samples_sent, colors_checked);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0 && expected_colors.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

### sim.f
hw/rtl/plc_pkg.sv
hw/rtl/plc_setup.sv
hw/rtl/plc_front.sv
hw/rtl/plc_fifo.sv
hw/rtl/plc_back.sv
hw/rtl/piecewise_linear_colormap.sv
verif/tb.sv
